// File: rtl/ped_pkg.sv
// ----------------------------------------------------------------------------
// Percent escape decoder package
// Character codes, status codes, escape phase type and the small
// character class functions used by the decoder core.
// ----------------------------------------------------------------------------
package ped_pkg;

   localparam int ByteWidth   = 8;
   localparam int StatusWidth = 2;
   localparam int NibbleWidth = 4;

   localparam logic [ByteWidth-1:0] ChPercent = 8'h25;
   localparam logic [ByteWidth-1:0] ChZero    = 8'h30;
   localparam logic [ByteWidth-1:0] ChNine    = 8'h39;
   localparam logic [ByteWidth-1:0] ChUpperA  = 8'h41;
   localparam logic [ByteWidth-1:0] ChUpperF  = 8'h46;
   localparam logic [ByteWidth-1:0] ChUpperZ  = 8'h5A;
   localparam logic [ByteWidth-1:0] ChLowerA  = 8'h61;
   localparam logic [ByteWidth-1:0] ChLowerF  = 8'h66;
   localparam logic [ByteWidth-1:0] ChLowerZ  = 8'h7A;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ESC   = 2'd1,
      ST_FORBIDDEN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   typedef struct packed {
      logic                 valid;
      logic [NibbleWidth-1:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [ByteWidth-1:0] b);
      hex_digit_type d;
      logic [ByteWidth-1:0] diff;
      d.valid = 1'b0;
      d.value = '0;
      diff    = '0;
      if (b >= ChZero && b <= ChNine) begin
         diff    = b - ChZero;
         d.valid = 1'b1;
         d.value = diff[NibbleWidth-1:0];
      end else if (b >= ChUpperA && b <= ChUpperF) begin
         diff    = b - ChUpperA + 8'd10;
         d.valid = 1'b1;
         d.value = diff[NibbleWidth-1:0];
      end else if (b >= ChLowerA && b <= ChLowerF) begin
         diff    = b - ChLowerA + 8'd10;
         d.valid = 1'b1;
         d.value = diff[NibbleWidth-1:0];
      end
      return d;
   endfunction

   function automatic logic is_alnum(input logic [ByteWidth-1:0] b);
      return (b >= ChZero && b <= ChNine) ||
             (b >= ChUpperA && b <= ChUpperZ) ||
             (b >= ChLowerA && b <= ChLowerZ);
   endfunction

endpackage

// File: rtl/percent_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// Percent escape decoder core
// Decodes a percent-escaped byte stream: alphanumerics pass, %XX gives one
// byte, errors end the message and the rest of it is dropped.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | tdata         | tuser          | tlast
//   req     | in        | in_byte [7:0] | -              | is_last
//   rsp     | out       | out_byte[7:0] | status [1:0]   | end_of_message
//
// One beat per cycle sustained. A beat sits in the input register, where
// the phase logic decodes it, and its result (if any) lands in the result
// register, which drives rsp_tvalid. A beat without a result never waits on
// rsp_tready; a beat with one waits in the input register while the result
// register is full and stalled. Synchronous active-high reset returns the
// escape phase to idle and clears the drop flag and both valid flags.
//
module percent_escape_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ped_pkg::ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ped_pkg::ByteWidth-1:0] rsp_tdata,   // [7:0] out_byte
   output logic [ped_pkg::StatusWidth-1:0] rsp_tuser, // [1:0] status
   output logic                        rsp_tlast
);
   import ped_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]   in_byte_ff;
   logic                   in_last_ff;

   phase_type              phase_ff, phase_in;
   logic [NibbleWidth-1:0] nibble_ff, nibble_in;
   logic                   dropping_ff, dropping_in;

   logic                   out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0]   out_byte_ff;
   status_type             out_status_ff;
   logic                   out_last_ff;

   logic                   has_result;
   logic [ByteWidth-1:0]   res_byte;
   status_type             res_status;
   logic                   res_last;
   hex_digit_type          digit;
   logic                   out_free;
   logic                   in_move;
   logic                   req_accept;

   assign digit = hex_digit(in_byte_ff);

   always_comb begin
      has_result  = 1'b0;
      res_byte    = '0;
      res_status  = ST_OK;
      res_last    = 1'b0;
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      dropping_in = dropping_ff;
      if (dropping_ff) begin
         if (in_last_ff) begin
            dropping_in = 1'b0;
            phase_in    = PH_IDLE;
            nibble_in   = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (!digit.valid || in_last_ff) begin
                  has_result = 1'b1;
                  res_status = ST_BAD_ESC;
                  res_last   = 1'b1;
                  phase_in   = PH_IDLE;
                  dropping_in = !in_last_ff;
               end else begin
                  nibble_in = digit.value;
                  phase_in  = PH_LOW;
               end
            end
            PH_LOW: begin
               has_result = 1'b1;
               phase_in   = PH_IDLE;
               nibble_in  = '0;
               if (!digit.valid) begin
                  res_status  = ST_BAD_ESC;
                  res_last    = 1'b1;
                  dropping_in = !in_last_ff;
               end else begin
                  res_byte = {nibble_ff, digit.value};
                  res_last = in_last_ff;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (in_byte_ff == ChPercent) begin
                  if (in_last_ff) begin
                     has_result = 1'b1;
                     res_status = ST_BAD_ESC;
                     res_last   = 1'b1;
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end else if (!is_alnum(in_byte_ff)) begin
                  has_result  = 1'b1;
                  res_status  = ST_FORBIDDEN;
                  res_last    = 1'b1;
                  dropping_in = !in_last_ff;
               end else begin
                  has_result = 1'b1;
                  res_byte   = in_byte_ff;
                  res_last   = in_last_ff;
               end
            end
         endcase
      end
   end

   // The held beat leaves when it has no result or the result slot frees up.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || in_move;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !in_move);
   assign out_valid_in = (in_move && has_result) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         nibble_ff    <= '0;
         dropping_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_move) begin
            phase_ff    <= phase_in;
            nibble_ff   <= nibble_in;
            dropping_ff <= dropping_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (in_move && has_result) begin
         out_byte_ff   <= res_byte;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   // An error result always closes the message and carries a zero byte.
   a_error_ends_message: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != ST_OK) |-> (out_last_ff && out_byte_ff == '0))
      else $error("error result without end of message or with nonzero byte");

   // While dropping, no escape is in progress.
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> (phase_ff == PH_IDLE))
      else $error("drop flag set with an escape in progress");

   // A beat that produces nothing while dropping never fills the result slot.
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (in_move && dropping_ff && !out_valid_ff) |=> !out_valid_ff)
      else $error("result produced while dropping");

endmodule

// File: sim/percent_escape_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Percent escape decoder core testbench
// Drives encoded messages into the decoder byte by byte. A behavioral decoder
// in the bench predicts each decoded beat. Directed cases cover pass-through,
// escapes, truncation, bad digits and forbidden bytes. Random messages follow,
// mostly well formed with some noise, under several sender and receiver
// idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core_test;
   import ped_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int PhaseBytes  = 305;
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      status_type           status;
      logic                 eom;
   } decoded_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ByteWidth-1:0]   req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [ByteWidth-1:0]   rsp_tdata;
   logic [StatusWidth-1:0] rsp_tuser;
   logic                   rsp_tlast;

   // Bench copy of the decoder state.
   phase_type              pred_phase    = PH_IDLE;
   logic [NibbleWidth-1:0] pred_high     = '0;
   logic                   pred_dropping = 1'b0;

   decoded_beat_type       pending_decoded[$];

   int tx_idle_pct   = 0;
   int rx_stall_pct  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int bytes_in      = 0;
   int beats_checked = 0;
   int error_endings = 0;
   int mismatches    = 0;

   logic                   seen_fire;
   logic [ByteWidth-1:0]   seen_data;
   logic [StatusWidth-1:0] seen_status;
   logic                   seen_eom;
   decoded_beat_type       oldest;

   percent_escape_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout with %0d decoded beats outstanding", $time,
                  pending_decoded.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Hex digit value in the low nibble; bit 4 set when the byte is no digit.
   function automatic logic [4:0] hex_nibble(input logic [ByteWidth-1:0] b);
      if (b >= ChZero && b <= ChNine) return 5'(b - ChZero);
      if (b >= ChUpperA && b <= ChUpperF) return 5'(b - ChUpperA + 8'd10);
      if (b >= ChLowerA && b <= ChLowerF) return 5'(b - ChLowerA + 8'd10);
      return 5'h10;
   endfunction

   function automatic logic alnum_byte(input logic [ByteWidth-1:0] b);
      return (b >= ChZero && b <= ChNine) || (b >= ChUpperA && b <= ChUpperZ) ||
             (b >= ChLowerA && b <= ChLowerZ);
   endfunction

   // Advances the bench decoder by one byte; returns 1 when a beat comes out.
   function automatic logic decode_byte(input logic [ByteWidth-1:0] b,
                                        input logic last,
                                        output decoded_beat_type beat);
      logic [4:0] nib;
      logic       failed;
      logic       produced;
      status_type st;
      nib      = hex_nibble(b);
      failed   = 1'b0;
      produced = 1'b0;
      st       = ST_BAD_ESC;
      beat     = '0;
      if (pred_dropping) begin
         if (last) begin
            pred_dropping = 1'b0;
            pred_phase    = PH_IDLE;
            pred_high     = '0;
         end
         return 1'b0;
      end
      if (pred_phase == PH_HIGH) begin
         if (nib[4] || last) begin
            failed = 1'b1;
         end else begin
            pred_high  = nib[3:0];
            pred_phase = PH_LOW;
         end
      end else if (pred_phase == PH_LOW) begin
         if (nib[4]) begin
            failed = 1'b1;
         end else begin
            beat.data   = {pred_high, nib[3:0]};
            beat.status = ST_OK;
            beat.eom    = last;
            pred_phase  = PH_IDLE;
            pred_high   = '0;
            produced    = 1'b1;
         end
      end else if (b == ChPercent) begin
         // A percent on the last byte can never complete its escape.
         if (last) failed = 1'b1;
         else pred_phase = PH_HIGH;
      end else if (!alnum_byte(b)) begin
         failed = 1'b1;
         st     = ST_FORBIDDEN;
      end else begin
         beat.data   = b;
         beat.status = ST_OK;
         beat.eom    = last;
         produced    = 1'b1;
      end
      if (failed) begin
         pred_phase    = PH_IDLE;
         pred_high     = '0;
         pred_dropping = !last;
         beat.data     = '0;
         beat.status   = st;
         beat.eom      = 1'b1;
         produced      = 1'b1;
      end
      return produced;
   endfunction

   // Called just after a rising edge; returns at the edge that accepts the beat.
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last);
      decoded_beat_type beat;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_in++;
      if (decode_byte(b, last, beat)) pending_decoded.push_back(beat);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [ByteWidth-1:0] random_alnum();
      int r;
      r = $urandom_range(61);
      if (r < 10) return 8'(ChZero + r);
      if (r < 36) return 8'(ChUpperA + (r - 10));
      return 8'(ChLowerA + (r - 36));
   endfunction

   function automatic logic [ByteWidth-1:0] random_hex_char();
      int r;
      r = $urandom_range(21);
      if (r < 10) return 8'(ChZero + r);
      if (r < 16) return 8'(ChUpperA + (r - 10));
      return 8'(ChLowerA + (r - 16));
   endfunction

   // Most messages are well formed; the rest mix in stray percents and any byte.
   task automatic send_random_message();
      logic [ByteWidth-1:0] msg[$];
      int tokens;
      int pick;
      logic clean;
      clean  = $urandom_range(99) < 80;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(99);
         if (clean) begin
            if (pick < 55) begin
               msg.push_back(random_alnum());
            end else begin
               msg.push_back(ChPercent);
               msg.push_back(random_hex_char());
               msg.push_back(random_hex_char());
            end
         end else begin
            case (pick % 4)
               0: msg.push_back(8'($urandom_range(255)));
               1: msg.push_back(ChPercent);
               2: msg.push_back(random_hex_char());
               default: msg.push_back(random_alnum());
            endcase
         end
      end
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
   endtask

   task automatic test_passthrough();
      send_text("Az");
      send_text("9");
   endtask

   task automatic test_escapes();
      send_text("%fF");
      send_text("%00Q");
   endtask

   task automatic test_truncated_escapes();
      send_text("%");
      send_text("%A");
   endtask

   task automatic test_bad_digits();
      // Bad high digit mid-message: the rest up to the last byte is dropped.
      send_text("%gx!");
      // Bad low digit on the last byte ends the message without dropping.
      send_text("%1:");
   endtask

   task automatic test_forbidden_bytes();
      send_text("/");
      send_text("0");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_random_messages(input int tx_pct, input int rx_pct);
      int target;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      target       = bytes_in + PhaseBytes;
      while (bytes_in < target) send_random_message();
   endtask

   // The receiver holds off while the sender keeps offering, so the core fills.
   task automatic test_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_left    = 150;
      for (int i = 0; i < 40; i++) send_byte(random_alnum(), i == 39);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left   = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rx_stall_pct;
      end
   end

   // Sample at the rising edge, compare at the falling edge.
   always begin
      @(posedge clock);
      seen_fire   = rsp_tvalid && rsp_tready && !reset;
      seen_data   = rsp_tdata;
      seen_status = rsp_tuser;
      seen_eom    = rsp_tlast;
      @(negedge clock);
      if (seen_fire) begin
         beats_checked++;
         if (seen_status != ST_OK) error_endings++;
         if (pending_decoded.size() == 0) begin
            mismatches++;
            if (mismatches <= 20)
               $display("%0t: unexpected beat, expected none, got data %02h status %0d eom %0b",
                        $time, seen_data, seen_status, seen_eom);
         end else begin
            oldest = pending_decoded.pop_front();
            if (seen_data !== oldest.data || seen_status !== oldest.status ||
                seen_eom !== oldest.eom) begin
               mismatches++;
               if (mismatches <= 20)
                  $display({"%0t: beat mismatch, expected data %02h status %0d eom %0b,",
                            " got data %02h status %0d eom %0b"},
                           $time, oldest.data, oldest.status, oldest.eom,
                           seen_data, seen_status, seen_eom);
            end
         end
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_passthrough();
      test_escapes();
      test_truncated_escapes();
      test_bad_digits();
      test_forbidden_bytes();
      test_random_messages(0, 0);
      test_backpressure();
      test_random_messages(72, 0);
      test_random_messages(0, 72);
      test_random_messages(20, 20);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_decoded.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d encoded bytes and %0d decoded beats, %0d of them error endings.",
               bytes_in, beats_checked, error_endings);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
